// ===== sv/lped_pkg.sv =====
package lped_pkg;

  // Header buffer size; a header holds at most HdrBufBytes-1 bytes
  localparam int HdrBufBytes = 16;
  localparam int HdrCntW     = $clog2(HdrBufBytes);

  // Depth of the command queue between front and back
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = QPtrW + 1;

  localparam int CfgAddrW = 4;

  // Register indexes on the configuration port (paddr[3:2])
  localparam logic [1:0] RegStartChar  = 2'd0;
  localparam logic [1:0] RegEndChar    = 2'd1;
  localparam logic [1:0] RegMaxEntry   = 2'd2;
  localparam logic [1:0] RegAppendNl   = 2'd3;

  localparam logic [7:0]  NewlineByte  = 8'd10;
  localparam logic [7:0]  StartReset   = 8'd126;
  localparam logic [7:0]  EndReset     = 8'd59;
  localparam logic [23:0] MaxEntryReset = 24'd2097152;

  // One unit of work for the back end
  typedef struct packed {
    logic [7:0]  data;   // payload byte or newline
    logic        has;    // 0 only for the empty-entry marker
    logic        last;   // final word of the entry
    logic [24:0] len;    // entry length; for a pair, the length of the newline word
    logic        pair;   // emit data (not last) then a closing newline
  } lped_cmd_t;

  typedef struct packed {
    logic avail;
    logic full;
  } lped_qstat_t;

endpackage

// ===== sv/lped_front.sv =====
module lped_front
  import lped_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  start_char,
  input  logic [7:0]  end_char,
  input  logic [23:0] max_entry_size,
  input  logic        append_newline,
  output logic        push,
  output lped_cmd_t   cmd
);

  localparam logic [1:0] ModeHunt    = 2'd0;
  localparam logic [1:0] ModeHeader  = 2'd1;
  localparam logic [1:0] ModePayload = 2'd2;

  localparam logic [1:0] PhSkip   = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhDone   = 2'd2;

  localparam logic [HdrCntW-1:0] HdrLast = HdrCntW'(HdrBufBytes - 1);
  localparam logic [30:0]        AccSat  = 31'h7FFF_FFFF;

  logic [1:0]         mode, mode_next;
  logic [HdrCntW-1:0] hcount, hcount_next;
  logic [30:0]        accum, accum_next;
  logic [1:0]         phase, phase_next;
  logic               neg, neg_next;
  logic [30:0]        remain, remain_next;
  logic [23:0]        dlen, dlen_next;
  logic               dropping, dropping_next;

  logic        digit;
  logic        space;
  logic        do_hunt;
  logic        do_acc;
  logic [34:0] acc_sum;

  assign digit = (data_byte >= 8'd48) && (data_byte <= 8'd57);
  assign space = (data_byte == 8'd32) || ((data_byte >= 8'd9) && (data_byte <= 8'd13));
  assign acc_sum = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + {31'b0, data_byte[3:0]};

  always_comb begin
    mode_next     = mode;
    hcount_next   = hcount;
    accum_next    = accum;
    phase_next    = phase;
    neg_next      = neg;
    remain_next   = remain;
    dlen_next     = dlen;
    dropping_next = dropping;
    push          = 1'b0;
    cmd           = '0;
    do_hunt       = 1'b0;
    do_acc        = 1'b0;

    if (accept) begin
      unique case (mode)
        ModeHeader: begin
          if (hcount == HdrLast) begin
            // header overflow: abandon it and look at this byte afresh
            do_hunt = 1'b1;
          end else if (data_byte == end_char) begin
            if (neg && (accum != '0)) begin
              mode_next = ModeHunt;
            end else if (accum == '0) begin
              mode_next = ModeHunt;
              push      = 1'b1;
              if (append_newline) begin
                cmd = '{data: NewlineByte, has: 1'b1, last: 1'b1, len: 25'd1, pair: 1'b0};
              end else begin
                cmd = '{data: 8'd0, has: 1'b0, last: 1'b1, len: 25'd0, pair: 1'b0};
              end
            end else begin
              mode_next     = ModePayload;
              remain_next   = accum;
              dlen_next     = accum[23:0];
              dropping_next = accum > {7'b0, max_entry_size};
            end
          end else begin
            hcount_next = hcount + 1'b1;
            unique case (phase)
              PhSkip: begin
                if (space) begin
                  phase_next = PhSkip;
                end else if (data_byte == 8'd43) begin
                  phase_next = PhDigits;
                end else if (data_byte == 8'd45) begin
                  phase_next = PhDigits;
                  neg_next   = 1'b1;
                end else if (digit) begin
                  phase_next = PhDigits;
                  do_acc     = 1'b1;
                end else begin
                  phase_next = PhDone;
                end
              end
              PhDigits: begin
                if (digit) begin
                  do_acc = 1'b1;
                end else begin
                  phase_next = PhDone;
                end
              end
              default: phase_next = phase;
            endcase
            if (do_acc) begin
              accum_next = (acc_sum > {4'b0, AccSat}) ? AccSat : acc_sum[30:0];
            end
          end
        end
        ModePayload: begin
          if (remain == 31'd1) begin
            mode_next     = ModeHunt;
            dropping_next = 1'b0;
            if (!dropping) begin
              push = 1'b1;
              if (append_newline && (data_byte != NewlineByte)) begin
                cmd = '{data: data_byte, has: 1'b1, last: 1'b0,
                        len: {1'b0, dlen} + 25'd1, pair: 1'b1};
              end else begin
                cmd = '{data: data_byte, has: 1'b1, last: 1'b1,
                        len: {1'b0, dlen}, pair: 1'b0};
              end
            end
          end else begin
            remain_next = remain - 31'd1;
            if (!dropping) begin
              push = 1'b1;
              cmd  = '{data: data_byte, has: 1'b1, last: 1'b0, len: 25'd0, pair: 1'b0};
            end
          end
        end
        default: do_hunt = 1'b1;
      endcase

      if (do_hunt) begin
        mode_next = ModeHunt;
        if (data_byte == start_char) begin
          mode_next     = ModeHeader;
          hcount_next   = '0;
          accum_next    = '0;
          phase_next    = PhSkip;
          neg_next      = 1'b0;
          dropping_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= ModeHunt;
      hcount   <= '0;
      accum    <= '0;
      phase    <= PhSkip;
      neg      <= 1'b0;
      dropping <= 1'b0;
      remain   <= '0;
    end else begin
      mode     <= mode_next;
      hcount   <= hcount_next;
      accum    <= accum_next;
      phase    <= phase_next;
      neg      <= neg_next;
      dropping <= dropping_next;
      remain   <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    dlen <= dlen_next;
  end

endmodule

// ===== sv/lped_queue.sv =====
module lped_queue
  import lped_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lped_cmd_t   push_cmd,
  input  logic        pop,
  output lped_cmd_t   head,
  output lped_qstat_t stat
);

  lped_cmd_t        mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.avail = (count != '0);
  assign stat.full  = (count == QCntW'(QDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/lped_back.sv =====
module lped_back
  import lped_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lped_cmd_t   head,
  input  lped_qstat_t stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        last,
  output logic [24:0] entry_length
);

  logic load;
  logic second;

  // load a new word whenever the output register is empty or being taken
  assign load = !out_valid || !out_stall;
  assign pop  = load && stat.avail && (!head.pair || second);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= stat.avail;
      if (stat.avail && head.pair) begin
        second <= !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && stat.avail) begin
      if (head.pair && second) begin
        out_byte     <= NewlineByte;
        has_byte     <= 1'b1;
        last         <= 1'b1;
        entry_length <= head.len;
      end else if (head.pair) begin
        out_byte     <= head.data;
        has_byte     <= 1'b1;
        last         <= 1'b0;
        entry_length <= 25'd0;
      end else begin
        out_byte     <= head.data;
        has_byte     <= head.has;
        last         <= head.last;
        entry_length <= head.len;
      end
    end
  end

endmodule

// ===== sv/length_prefixed_entry_deframer_top.sv =====
// Length-prefixed entry deframer.
// Input channel: one raw stream byte per word on data_byte, moved when
// in_valid is high and in_stall is low. The block hunts for start_char, reads
// a decimal length header up to end_char, then passes the payload through.
// Output channel: one word per payload byte of entries up to max_entry_size
// (out_byte, has_byte, last, entry_length), moved when out_valid is high and
// out_stall is low. An optional newline word closes entries not ending in one;
// an empty entry gives one word (a newline, or a marker with has_byte low).
// Path: the front parser pushes a command into the queue at the edge that
// accepts the input word causing it, and the back output register loads it
// from the queue whenever that register is empty or being taken.
// Throughput: one input word per cycle. An appended newline adds one extra
// output word; the four-entry command queue absorbs it, and in_stall rises
// only when that queue is full.
// Receiver stall: the output register holds its word, the queue fills, and
// the input side stalls once the queue is full.
// Reset (rst, synchronous): the parser returns to hunting, the queue and
// output register empty, and the configuration registers take their defaults.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12.
module length_prefixed_entry_deframer_top
  import lped_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                has_byte,
  output logic                last,
  output logic [24:0]         entry_length
);

  logic [7:0]  start_char;
  logic [7:0]  end_char;
  logic [23:0] max_entry_size;
  logic        append_newline;

  logic        cfg_wr;
  logic        in_accept;
  logic        push;
  logic        pop;
  lped_cmd_t   push_cmd;
  lped_cmd_t   head;
  lped_qstat_t qstat;

  // Configuration registers: written in the access phase, read back at once
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char     <= StartReset;
      end_char       <= EndReset;
      max_entry_size <= MaxEntryReset;
      append_newline <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegStartChar: start_char     <= pwdata[7:0];
        RegEndChar:   end_char       <= pwdata[7:0];
        RegMaxEntry:  max_entry_size <= pwdata[23:0];
        RegAppendNl:  append_newline <= pwdata[0];
        default:      start_char     <= start_char;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegStartChar: prdata = {24'b0, start_char};
      RegEndChar:   prdata = {24'b0, end_char};
      RegMaxEntry:  prdata = {8'b0, max_entry_size};
      RegAppendNl:  prdata = {31'b0, append_newline};
      default:      prdata = '0;
    endcase
  end

  // Hold input words while the command queue has no room
  assign in_stall  = qstat.full;
  assign in_accept = in_valid && !in_stall;

  lped_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .data_byte      (data_byte),
    .start_char     (start_char),
    .end_char       (end_char),
    .max_entry_size (max_entry_size),
    .append_newline (append_newline),
    .push           (push),
    .cmd            (push_cmd)
  );

  lped_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  lped_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .stat         (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .last         (last),
    .entry_length (entry_length)
  );

`ifndef ASSERT_OFF
  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("command queue written while full");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.avail)
    else $error("command queue read while empty");

  // An empty-entry marker always closes its entry with zero length
  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> (last && (entry_length == 25'd0)))
    else $error("empty-entry marker malformed");

  // Length is reported only on the closing word
  a_len_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (entry_length == 25'd0))
    else $error("entry length on a non-final word");

  // Output register is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== bench/deframe_checker.sv =====
`timescale 1ns / 100ps
module deframe_checker
  import lped_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [7:0]          out_byte,
  input  logic                has_byte,
  input  logic                last,
  input  logic [24:0]         entry_length,
  output int                  fails,
  output int                  pending
);

  localparam logic [31:0] AccumSat  = 32'd2147483647;
  localparam logic [7:0]  PlusChar  = 8'd43;
  localparam logic [7:0]  MinusChar = 8'd45;
  localparam logic [7:0]  ZeroChar  = 8'd48;
  localparam logic [7:0]  NineChar  = 8'd57;
  localparam logic [7:0]  SpaceChar = 8'd32;
  localparam logic [7:0]  TabChar   = 8'd9;
  localparam logic [7:0]  CrChar    = 8'd13;

  typedef enum logic [1:0] {SEEK_START, IN_HEADER, IN_PAYLOAD} parse_mode_t;
  typedef enum logic [1:0] {SKIP_SPACE, IN_DIGITS, NUMBER_DONE} num_phase_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        has;
    logic        lst;
    logic [24:0] len;
  } out_word_t;

  logic [7:0]  start_c, end_c;
  logic [23:0] max_len;
  logic        add_nl;

  parse_mode_t mode;
  num_phase_t  phase;
  logic [4:0]  hdr_cnt;
  logic [31:0] accum, pos, ent_len;
  logic        neg, dropping;

  out_word_t due_words[$];
  int        n_fail = 0;

  task automatic queue_word(logic [7:0] d, logic h, logic l, logic [24:0] n);
    out_word_t w;
    w = '{data: d, has: h, lst: l, len: n};
    due_words.push_back(w);
  endtask

  task automatic look_for_start(logic [7:0] b);
    mode = SEEK_START;
    if (b == start_c) begin
      mode     = IN_HEADER;
      hdr_cnt  = 0;
      accum    = 0;
      phase    = SKIP_SPACE;
      neg      = 0;
      pos      = 0;
      ent_len  = 0;
      dropping = 0;
    end
  endtask

  // Advance the parser by one stream byte and queue the words it yields
  task automatic deframe_byte(logic [7:0] b);
    logic        digit, no_digit;
    logic [31:0] d;
    digit    = (b >= ZeroChar) && (b <= NineChar);
    d        = {24'd0, b - ZeroChar};
    no_digit = 0;
    if (mode == IN_HEADER) begin
      if (hdr_cnt >= HdrBufBytes - 1) begin
        look_for_start(b);
      end else if (b == end_c) begin
        if (neg && accum != 0) begin
          mode = SEEK_START;
        end else begin
          ent_len  = accum;
          pos      = 0;
          dropping = ent_len > {8'd0, max_len};
          if (ent_len == 0) begin
            mode = SEEK_START;
            if (add_nl) queue_word(NewlineByte, 1'b1, 1'b1, 25'd1);
            else queue_word(8'd0, 1'b0, 1'b1, 25'd0);
          end else begin
            mode = IN_PAYLOAD;
          end
        end
      end else begin
        if (phase == SKIP_SPACE) begin
          if (b == SpaceChar || (b >= TabChar && b <= CrChar)) begin
            no_digit = 1;
          end else if (b == PlusChar) begin
            phase    = IN_DIGITS;
            no_digit = 1;
          end else if (b == MinusChar) begin
            neg      = 1;
            phase    = IN_DIGITS;
            no_digit = 1;
          end else begin
            phase = digit ? IN_DIGITS : NUMBER_DONE;
          end
        end else if (phase == IN_DIGITS && !digit) begin
          phase = NUMBER_DONE;
        end
        if (!no_digit && phase == IN_DIGITS && digit) begin
          if (accum > (AccumSat - d) / 10) accum = AccumSat;
          else accum = accum * 10 + d;
        end
        hdr_cnt = hdr_cnt + 5'd1;
      end
    end else if (mode == IN_PAYLOAD) begin
      pos = pos + 32'd1;
      if (pos >= ent_len) begin
        mode = SEEK_START;
        if (dropping) begin
          dropping = 0;
        end else if (add_nl && b != NewlineByte) begin
          queue_word(b, 1'b1, 1'b0, 25'd0);
          queue_word(NewlineByte, 1'b1, 1'b1, ent_len[24:0] + 25'd1);
        end else begin
          queue_word(b, 1'b1, 1'b1, ent_len[24:0]);
        end
      end else if (!dropping) begin
        queue_word(b, 1'b1, 1'b0, 25'd0);
      end
    end else begin
      look_for_start(b);
    end
  endtask

  task automatic check_field(string name, logic [24:0] want, logic [24:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t w;
    if (rst) begin
      start_c  = StartReset;
      end_c    = EndReset;
      max_len  = MaxEntryReset;
      add_nl   = 1;
      mode     = SEEK_START;
      phase    = SKIP_SPACE;
      hdr_cnt  = 0;
      accum    = 0;
      neg      = 0;
      pos      = 0;
      ent_len  = 0;
      dropping = 0;
      due_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegStartChar: start_c = pwdata[7:0];
          RegEndChar:   end_c   = pwdata[7:0];
          RegMaxEntry:  max_len = pwdata[23:0];
          RegAppendNl:  add_nl  = pwdata[0];
          default: ;
        endcase
      end
      // Check the outgoing word before queueing anything from this edge
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word, actual byte %0d has %0d last %0d length %0d",
                   $time, out_byte, has_byte, last, entry_length);
          n_fail++;
        end else begin
          w = due_words.pop_front();
          check_field("out_byte", {17'd0, w.data}, {17'd0, out_byte});
          check_field("has_byte", {24'd0, w.has}, {24'd0, has_byte});
          check_field("last", {24'd0, w.lst}, {24'd0, last});
          check_field("entry_length", w.len, entry_length);
        end
      end
      if (in_valid && !in_stall) deframe_byte(data_byte);
    end
    fails   <= n_fail;
    pending <= due_words.size();
  end

endmodule

// ===== bench/length_prefixed_entry_deframer_top_test.sv =====
`timescale 1ns / 100ps
module length_prefixed_entry_deframer_top_test;
  import lped_pkg::*;

  // Cycles with no word moved on any port before the run is declared hung;
  // well above the long receiver hold-off plus the worst idle gaps
  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 150;

  localparam logic [7:0] MinusChar = 8'd45;
  localparam logic [7:0] PlusChar  = 8'd43;
  localparam logic [7:0] ZeroChar  = 8'd48;
  localparam logic [7:0] SpaceChar = 8'd32;
  localparam logic [7:0] TabChar   = 8'd9;

  logic                clk = 0;
  logic                rst = 1;
  logic                psel = 0;
  logic                penable = 0;
  logic                pwrite = 0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 0;
  logic                in_stall;
  logic [7:0]          data_byte = '0;
  logic                out_valid;
  logic                out_stall = 0;
  logic [7:0]          out_byte;
  logic                has_byte;
  logic                last;
  logic [24:0]         entry_length;
  int                  fails;
  int                  pending;

  // Stimulus-side copy of the settings, used to shape well-formed entries
  logic [7:0]  start_c = StartReset;
  logic [7:0]  end_c   = EndReset;
  logic [23:0] max_len = MaxEntryReset;

  bit tx_idle  = 1;
  bit hold_req = 0;
  int quiet    = 0;

  always #5 clk = ~clk;

  length_prefixed_entry_deframer_top u_top (.*);

  deframe_checker u_check (.*);

  // Hang detection: count edges at which no word moves anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall before each word, with stretches of no stalling,
  // and one long hold-off on request so the queue fills and the input stalls
  initial begin : receiver
    int  gap;
    bit  rx_idle;
    rx_idle = 1;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 0;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_idle = !rx_idle;
        gap = rx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
          out_stall <= 1;
          repeat (gap) @(posedge clk);
          out_stall <= 0;
        end
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one stream byte, after a random gap while tx_idle is set, and hold it until taken
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  function automatic logic [7:0] pick_space();
    int p;
    p = $urandom_range(0, 5);
    return (p == 5) ? SpaceChar : TabChar + p[7:0];
  endfunction

  // One framed entry: start, optional whitespace, sign and leading zero,
  // the number, optional trailing junk, end, then the payload bytes
  task automatic send_entry(string num, bit negative, int pay);
    send_byte(start_c);
    if ($urandom_range(0, 2) == 0) send_byte(pick_space());
    if (negative) send_byte(MinusChar);
    else if ($urandom_range(0, 3) == 0) send_byte(PlusChar);
    if ($urandom_range(0, 3) == 0) send_byte(ZeroChar);
    send_text(num);
    if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(58, 126)));
    send_byte(end_c);
    for (int k = 0; k < pay; k++) begin
      if (k == pay - 1 && $urandom_range(0, 2) == 0) send_byte(NewlineByte);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Malformed traffic: overlong headers, huge negative lengths, loose noise
  task automatic send_broken();
    case ($urandom_range(0, 2))
      0: begin
        send_byte(start_c);
        repeat (HdrBufBytes - 1) begin
          if ($urandom_range(0, 1) == 0) send_byte(pick_space());
          else send_byte(ZeroChar + 8'($urandom_range(1, 9)));
        end
        send_byte($urandom_range(0, 1) == 0 ? end_c : start_c);
      end
      1: send_entry("99999999", 1'b1, 0);
      default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Mostly well-formed entries with random content, the rest malformed traffic
  task automatic send_phase(int items);
    int n;
    int sent;
    bit negative;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 11) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 7) == 0 && max_len < 64) n = max_len + $urandom_range(1, 3);
        else n = $urandom_range(0, 6);
        negative = ($urandom_range(0, 9) == 0);
        send_entry($sformatf("%0d", n), negative, (negative && n != 0) ? 0 : n);
        sent += 6 + n;
      end else begin
        send_broken();
        sent += 4;
      end
    end
  endtask

  // Drop valid, wait for every outstanding word, then let the pipe drain
  task automatic settle(int drain);
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (drain) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(logic [7:0] s, logic [7:0] e, logic [23:0] m, logic nl);
    write_reg(RegStartChar, {24'd0, s});
    write_reg(RegEndChar, {24'd0, e});
    write_reg(RegMaxEntry, {8'd0, m});
    write_reg(RegAppendNl, {31'd0, nl});
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    start_c = s;
    end_c   = e;
    max_len = m;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: empty entry, negative length, minus zero, explicit plus with
    // the byte extremes as payload, and a payload already ending in newline
    send_text("~0;~ -3;~-0;~+2;");
    send_byte(8'd255);
    send_byte(8'd0);
    send_text("~1;\n");
    send_phase(PhaseItems);

    for (int ph = 1; ph <= 5; ph++) begin
      settle(6);
      case (ph)
        1: configure(8'd0, 8'd255, 24'd0, 1'b0);
        2: configure(8'd255, 8'd0, 24'hFFFFFF, 1'b1);
        3: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 24'd5, 1'b0);
        4: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     24'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
        default: configure(StartReset, EndReset, 24'd3, 1'b1);
      endcase
      // Long receiver hold-off while entries with many words keep coming
      if (ph == 2) hold_req = 1;
      send_phase(PhaseItems);
    end

    // Saturating length: the block swallows everything after this header
    send_entry("9999999999", 1'b0, 30);
    settle(16);

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
